[sv/afi_pkg.sv]
// afi_pkg: shared constants, sideband type and angle table for the AFI voxel engine.
// No dependencies; imported by every module of the block.
package afi_pkg;

    localparam int MAG_BITS_DEF   = 12;
    localparam int PHASE_BITS_DEF = 13;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_REP_RATIO = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_ANGLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B0_FIRST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_B0_SECOND = 3'd4;

    localparam logic [15:0] REP_RATIO_RST = 16'd20480;
    localparam logic [15:0] INV_ANGLE_RST = 16'd1092;
    localparam logic [11:0] CUTOFF_RST    = 12'd100;
    localparam logic [15:0] B0_SCALE_RST  = 16'd16000;

    localparam int SQRT_STEPS   = 32;
    localparam int CORDIC_STEPS = 20;
    localparam int CW           = 36;   // cordic x/y width
    localparam int ZW           = 26;   // angle accumulator width, degrees Q16
    localparam int ZCW          = 24;   // clamped angle width

    localparam logic signed [ZW-1:0] Z_90  = ZW'(90 * 65536);
    localparam logic signed [ZW-1:0] Z_180 = ZW'(180 * 65536);

    typedef struct packed {
        logic [15:0] b0_first;
        logic [15:0] b0_second;
        logic        in_mask;
        logic        ratio_invalid;
    } side_t;

    function automatic logic signed [ZW-1:0] atan_deg_q16(input int idx);
        logic signed [ZW-1:0] a;
        case (idx)
            0:       a = ZW'(2949120);
            1:       a = ZW'(1740967);
            2:       a = ZW'(919879);
            3:       a = ZW'(466945);
            4:       a = ZW'(234379);
            5:       a = ZW'(117304);
            6:       a = ZW'(58666);
            7:       a = ZW'(29335);
            8:       a = ZW'(14668);
            9:       a = ZW'(7334);
            10:      a = ZW'(3667);
            11:      a = ZW'(1833);
            12:      a = ZW'(917);
            13:      a = ZW'(458);
            14:      a = ZW'(229);
            15:      a = ZW'(115);
            16:      a = ZW'(57);
            17:      a = ZW'(29);
            18:      a = ZW'(14);
            19:      a = ZW'(7);
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

[sv/afi_front.sv]
// afi_front: phase wrap, B0 offsets, acos fraction, validity and pre-scaling for the root.
// Depends on afi_pkg.
module afi_front
    import afi_pkg::*;
#(
    parameter int MAG_BITS   = MAG_BITS_DEF,
    parameter int PHASE_BITS = PHASE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic [MAG_BITS-1:0]           mag_a,
    input  logic [MAG_BITS-1:0]           mag_b,
    input  logic [MAG_BITS-1:0]           mag_c,
    input  logic [MAG_BITS-1:0]           mag_d,
    input  logic signed [PHASE_BITS-1:0]  pha_a,
    input  logic signed [PHASE_BITS-1:0]  pha_b,
    input  logic signed [PHASE_BITS-1:0]  pha_c,
    input  logic signed [PHASE_BITS-1:0]  pha_d,
    input  logic [15:0]                   rep_ratio,
    input  logic [11:0]                   cutoff,
    input  logic [15:0]                   scale_first,
    input  logic [15:0]                   scale_second,
    output logic                          valid,
    output logic [31:0]                   s_sh,
    output logic [31:0]                   t_sh,
    output logic signed [MAG_BITS+17:0]   x_sh,
    output side_t                         side
);

    localparam int NW   = MAG_BITS + 18;
    localparam int DW   = PHASE_BITS + 1;
    localparam int BW   = PHASE_BITS + 18;
    localparam int PW   = MAG_BITS + 16;
    localparam int CMPW = (MAG_BITS > 12) ? MAG_BITS : 12;
    localparam logic signed [BW-1:0] B0_HALF = BW'(1) <<< (PHASE_BITS - 1);

    function automatic logic signed [DW-1:0] wrap_diff(
        input logic signed [PHASE_BITS-1:0] a,
        input logic signed [PHASE_BITS-1:0] b
    );
        logic signed [DW:0] d;
        logic signed [DW:0] half;
        logic signed [DW:0] full;
        half = (DW+1)'(1) <<< (PHASE_BITS - 1);
        full = (DW+1)'(1) <<< PHASE_BITS;
        d    = (DW+1)'(b) - (DW+1)'(a);
        if (d > half)
            d = d - full;
        if (d <= -half)
            d = d + full;
        return DW'(d);
    endfunction

    function automatic logic [15:0] b0_round(
        input logic signed [BW-1:0] p,
        input logic                 zero
    );
        logic signed [BW-1:0] q;
        logic [15:0]          r;
        q = (p + B0_HALF) >>> PHASE_BITS;
        if (zero)
            r = '0;
        else if (q > BW'(32767))
            r = 16'h7FFF;
        else if (q < -BW'(32768))
            r = 16'h8000;
        else
            r = q[15:0];
        return r;
    endfunction

    logic [4:0] vld_reg;

    // stage 1
    logic signed [DW-1:0] s1_d01, s1_d02_reg, s1_d23_reg;
    logic                 s1_f_reg;
    logic [PW-1:0]        s1_bn_reg, s1_an_reg;
    logic [MAG_BITS-1:0]  s1_ma_reg, s1_mb_reg;
    logic                 s1_mask_reg, s1_za_reg, s1_zc_reg, s1_zd_reg;
    logic [DW-1:0]        s1_abs;

    // stage 2
    logic signed [BW-1:0] s2_bp1_reg, s2_bp2_reg;
    logic signed [NW-1:0] s2_num_reg, s2_den_reg;
    logic                 s2_mask_reg, s2_za_reg, s2_zc_reg, s2_zd_reg;
    logic signed [NW-1:0] s2_bn, s2_an, s2_a12, s2_b12;
    logic signed [BW-1:0] s2_d02e, s2_d23e, s2_sc1, s2_sc2;

    // stage 3
    side_t                s3_side_reg;
    logic signed [NW-1:0] s3_num_reg, s3_den_reg;
    logic [NW-1:0]        s3_anum, s3_aden;

    // stage 4
    side_t                s4_side_reg;
    logic [NW-1:0]        s4_s_reg, s4_t_reg;
    logic signed [NW-1:0] s4_x_reg;

    // stage 5
    logic [63:0] st64, s64, t64;
    logic [5:0]  k;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[3:0], in_valid};
    end

    assign valid = vld_reg[4];

    assign s1_d01 = wrap_diff(pha_a, pha_b);
    assign s1_abs = (s1_d01 < 0) ? DW'(-s1_d01) : DW'(s1_d01);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_d02_reg  <= wrap_diff(pha_a, pha_c);
            s1_d23_reg  <= wrap_diff(pha_c, pha_d);
            s1_f_reg    <= (s1_abs >= (DW'(1) << (PHASE_BITS - 2)));
            s1_bn_reg   <= PW'(mag_b) * PW'(rep_ratio);
            s1_an_reg   <= PW'(mag_a) * PW'(rep_ratio);
            s1_ma_reg   <= mag_a;
            s1_mb_reg   <= mag_b;
            s1_mask_reg <= (CMPW'(mag_a) >= CMPW'(cutoff));
            s1_za_reg   <= (mag_a == '0);
            s1_zc_reg   <= (mag_c == '0);
            s1_zd_reg   <= (mag_d == '0);
        end
    end

    assign s2_bn   = $signed(NW'(s1_bn_reg));
    assign s2_an   = $signed(NW'(s1_an_reg));
    assign s2_a12  = $signed(NW'({s1_ma_reg, 12'b0}));
    assign s2_b12  = $signed(NW'({s1_mb_reg, 12'b0}));
    assign s2_d02e = BW'(s1_d02_reg);
    assign s2_d23e = BW'(s1_d23_reg);
    assign s2_sc1  = $signed(BW'(scale_first));
    assign s2_sc2  = $signed(BW'(scale_second));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_bp1_reg  <= s2_d02e * s2_sc1;
            s2_bp2_reg  <= s2_d23e * s2_sc2;
            s2_num_reg  <= s1_f_reg ? (-s2_bn - s2_a12) : (s2_bn - s2_a12);
            s2_den_reg  <= s1_f_reg ? (s2_an + s2_b12) : (s2_an - s2_b12);
            s2_mask_reg <= s1_mask_reg;
            s2_za_reg   <= s1_za_reg;
            s2_zc_reg   <= s1_zc_reg;
            s2_zd_reg   <= s1_zd_reg;
        end
    end

    assign s3_anum = (s2_num_reg < 0) ? NW'(-s2_num_reg) : NW'(s2_num_reg);
    assign s3_aden = (s2_den_reg < 0) ? NW'(-s2_den_reg) : NW'(s2_den_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_side_reg.b0_first      <= b0_round(s2_bp1_reg, s2_za_reg | s2_zc_reg);
            s3_side_reg.b0_second     <= b0_round(s2_bp2_reg, s2_zc_reg | s2_zd_reg);
            s3_side_reg.in_mask       <= s2_mask_reg;
            s3_side_reg.ratio_invalid <= s2_za_reg || (s2_den_reg == '0)
                                         || (s3_anum > s3_aden);
            s3_num_reg <= (s2_den_reg < 0) ? -s2_num_reg : s2_num_reg;
            s3_den_reg <= (s2_den_reg < 0) ? -s2_den_reg : s2_den_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_side_reg <= s3_side_reg;
            s4_s_reg    <= NW'(s3_den_reg - s3_num_reg);
            s4_t_reg    <= NW'(s3_den_reg + s3_num_reg);
            s4_x_reg    <= s3_num_reg;
        end
    end

    // scale both root operands below 2^32
    assign s64  = 64'(s4_s_reg);
    assign t64  = 64'(s4_t_reg);
    assign st64 = s64 | t64;

    always_comb
    begin
        k = '0;
        for (int i = 32; i < 64; i++)
        begin
            if (st64[i])
                k = 6'(i - 31);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side <= s4_side_reg;
            s_sh <= 32'(s64 >> k);
            t_sh <= 32'(t64 >> k);
            x_sh <= s4_x_reg >>> k;
        end
    end

endmodule

[sv/afi_isqrt.sv]
// afi_isqrt: pipelined 64-bit integer square root of s*t, one result bit per stage.
// Depends on afi_pkg.
module afi_isqrt
    import afi_pkg::*;
#(
    parameter int MAG_BITS = MAG_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic                         in_valid,
    input  logic [31:0]                  s_sh,
    input  logic [31:0]                  t_sh,
    input  logic signed [MAG_BITS+17:0]  x_in,
    input  side_t                        side_in,
    output logic                         valid,
    output logic [31:0]                  root,
    output logic signed [MAG_BITS+17:0]  x_out,
    output side_t                        side_out
);

    localparam int NW = MAG_BITS + 18;

    logic [SQRT_STEPS:0]  vld_reg;
    logic [63:0]          v_reg [0:SQRT_STEPS];
    logic [63:0]          r_reg [1:SQRT_STEPS];
    logic signed [NW-1:0] x_reg [0:SQRT_STEPS];
    side_t                side_reg [0:SQRT_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[SQRT_STEPS-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v_reg[0]    <= 64'(s_sh) * 64'(t_sh);
            x_reg[0]    <= x_in;
            side_reg[0] <= side_in;
        end
    end

    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_step
        localparam logic [63:0] BIT = 64'(1) << (62 - 2 * j);
        logic [63:0] r_prev;
        logic [63:0] trial;

        if (j == 0)
        begin : g_first
            assign r_prev = '0;
        end
        else
        begin : g_rest
            assign r_prev = r_reg[j];
        end

        assign trial = r_prev + BIT;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (v_reg[j] >= trial)
                begin
                    v_reg[j+1] <= v_reg[j] - trial;
                    r_reg[j+1] <= (r_prev >> 1) + BIT;
                end
                else
                begin
                    v_reg[j+1] <= v_reg[j];
                    r_reg[j+1] <= r_prev >> 1;
                end
                x_reg[j+1]    <= x_reg[j];
                side_reg[j+1] <= side_reg[j];
            end
        end
    end

    assign valid    = vld_reg[SQRT_STEPS];
    assign root     = r_reg[SQRT_STEPS][31:0];
    assign x_out    = x_reg[SQRT_STEPS];
    assign side_out = side_reg[SQRT_STEPS];

endmodule

[sv/afi_cordic.sv]
// afi_cordic: normalize, fold into the right half plane and run a vectoring CORDIC
// giving the angle in degrees Q16, clamped to [0, 180]. Depends on afi_pkg.
module afi_cordic
    import afi_pkg::*;
#(
    parameter int MAG_BITS = MAG_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic                         in_valid,
    input  logic [31:0]                  y_in,
    input  logic signed [MAG_BITS+17:0]  x_in,
    input  side_t                        side_in,
    output logic                         valid,
    output logic [ZCW-1:0]               angle,
    output side_t                        side_out
);

    localparam int NS = CORDIC_STEPS + 4;

    logic [NS-1:0] vld_reg;

    logic signed [CW-1:0] xe, ax;
    logic [CW-1:0]        m;
    logic [5:0]           p;
    logic [4:0]           n;

    logic signed [CW-1:0] n1_x_reg, n1_y_reg;
    logic [4:0]           n1_n_reg;
    side_t                n1_side_reg;

    logic signed [CW-1:0] n2_x_reg, n2_y_reg;
    side_t                n2_side_reg;

    logic signed [CW-1:0] cx_reg [0:CORDIC_STEPS];
    logic signed [CW-1:0] cy_reg [0:CORDIC_STEPS];
    logic signed [ZW-1:0] cz_reg [0:CORDIC_STEPS];
    side_t                cs_reg [0:CORDIC_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NS-2:0], in_valid};
    end

    assign xe = CW'(x_in);
    assign ax = (xe < 0) ? -xe : xe;
    assign m  = CW'(ax) | CW'(y_in);

    always_comb
    begin
        p = '0;
        for (int i = 0; i < CW; i++)
        begin
            if (m[i])
                p = 6'(i);
        end
        if (m == '0 || p >= 6'd30)
            n = '0;
        else
            n = 5'(6'd30 - p);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n1_x_reg    <= xe;
            n1_y_reg    <= $signed(CW'(y_in));
            n1_n_reg    <= n;
            n1_side_reg <= side_in;

            n2_x_reg    <= n1_x_reg <<< n1_n_reg;
            n2_y_reg    <= n1_y_reg <<< n1_n_reg;
            n2_side_reg <= n1_side_reg;

            if (n2_x_reg < 0)
            begin
                cx_reg[0] <= n2_y_reg;
                cy_reg[0] <= -n2_x_reg;
                cz_reg[0] <= Z_90;
            end
            else
            begin
                cx_reg[0] <= n2_x_reg;
                cy_reg[0] <= n2_y_reg;
                cz_reg[0] <= '0;
            end
            cs_reg[0] <= n2_side_reg;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_rot
        localparam logic signed [ZW-1:0] ATAN = atan_deg_q16(i);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (cy_reg[i] > 0)
                begin
                    cx_reg[i+1] <= cx_reg[i] + (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] - (cx_reg[i] >>> i);
                    cz_reg[i+1] <= cz_reg[i] + ATAN;
                end
                else
                begin
                    cx_reg[i+1] <= cx_reg[i] - (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] + (cx_reg[i] >>> i);
                    cz_reg[i+1] <= cz_reg[i] - ATAN;
                end
                cs_reg[i+1] <= cs_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (cz_reg[CORDIC_STEPS] < 0)
                angle <= '0;
            else if (cz_reg[CORDIC_STEPS] > Z_180)
                angle <= ZCW'(Z_180);
            else
                angle <= ZCW'(cz_reg[CORDIC_STEPS]);
            side_out <= cs_reg[CORDIC_STEPS];
        end
    end

    assign valid = vld_reg[NS-1];

endmodule

[sv/afi_flip_angle_b0_voxel.sv]
// afi_flip_angle_b0_voxel: top level of the AFI flip-angle and B0 voxel engine.
// Holds the configuration registers and the final scaling; uses afi_pkg,
// afi_front, afi_isqrt and afi_cordic.
//
// Usage:
//   Input channel: in_valid / in_stall carry one voxel word (four magnitudes,
//   four phases). Output channel: out_valid / out_stall carry one result word
//   (two B0 offsets, flip ratio, mask and invalid flags) per voxel, in order.
//   Configuration: cfg_write with cfg_index / cfg_data writes one register per
//   cycle; write only while the pipeline is empty.
//   Throughput: one voxel per clock while out_stall does not freeze the pipeline.
//   Pipeline: 64 register stages (5 front, 33 square root, 24 CORDIC, 2 scaling).
//   Reset: all valid bits clear, registers take their default values, the
//   engine accepts a word in the first cycle after reset.
//   Stall: out_stall with a word waiting freezes the whole pipeline; in_stall
//   is raised in the same cycle, nothing is dropped or repeated.
module afi_flip_angle_b0_voxel
    import afi_pkg::*;
#(
    parameter int MAG_BITS   = MAG_BITS_DEF,
    parameter int PHASE_BITS = PHASE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [MAG_BITS-1:0]           mag_a,
    input  logic [MAG_BITS-1:0]           mag_b,
    input  logic [MAG_BITS-1:0]           mag_c,
    input  logic [MAG_BITS-1:0]           mag_d,
    input  logic signed [PHASE_BITS-1:0]  pha_a,
    input  logic signed [PHASE_BITS-1:0]  pha_b,
    input  logic signed [PHASE_BITS-1:0]  pha_c,
    input  logic signed [PHASE_BITS-1:0]  pha_d,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [15:0]            b0_first,
    output logic signed [15:0]            b0_second,
    output logic [19:0]                   flip_ratio,
    output logic                          in_mask,
    output logic                          ratio_invalid
);

    localparam int NW = MAG_BITS + 18;
    localparam int MW = ZCW + 16;

    logic [15:0] rep_ratio_reg;
    logic [15:0] inv_angle_reg;
    logic [11:0] cutoff_reg;
    logic [15:0] b0_first_scale_reg;
    logic [15:0] b0_second_scale_reg;

    logic adv;

    logic                 fr_valid;
    logic [31:0]          fr_s, fr_t;
    logic signed [NW-1:0] fr_x;
    side_t                fr_side;

    logic                 sq_valid;
    logic [31:0]          sq_root;
    logic signed [NW-1:0] sq_x;
    side_t                sq_side;

    logic                 cd_valid;
    logic [ZCW-1:0]       cd_angle;
    side_t                cd_side;

    logic                 mul_valid_reg;
    logic [MW-1:0]        mul_reg;
    side_t                mul_side_reg;

    logic [MW:0]          rnd;
    logic [20:0]          q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rep_ratio_reg       <= REP_RATIO_RST;
            inv_angle_reg       <= INV_ANGLE_RST;
            cutoff_reg          <= CUTOFF_RST;
            b0_first_scale_reg  <= B0_SCALE_RST;
            b0_second_scale_reg <= B0_SCALE_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_REP_RATIO: rep_ratio_reg       <= cfg_data;
                REG_INV_ANGLE: inv_angle_reg       <= cfg_data;
                REG_CUTOFF:    cutoff_reg          <= cfg_data[11:0];
                REG_B0_FIRST:  b0_first_scale_reg  <= cfg_data;
                REG_B0_SECOND: b0_second_scale_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    afi_front #(
        .MAG_BITS   (MAG_BITS),
        .PHASE_BITS (PHASE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .in_valid     (in_valid),
        .mag_a        (mag_a),
        .mag_b        (mag_b),
        .mag_c        (mag_c),
        .mag_d        (mag_d),
        .pha_a        (pha_a),
        .pha_b        (pha_b),
        .pha_c        (pha_c),
        .pha_d        (pha_d),
        .rep_ratio    (rep_ratio_reg),
        .cutoff       (cutoff_reg),
        .scale_first  (b0_first_scale_reg),
        .scale_second (b0_second_scale_reg),
        .valid        (fr_valid),
        .s_sh         (fr_s),
        .t_sh         (fr_t),
        .x_sh         (fr_x),
        .side         (fr_side)
    );

    afi_isqrt #(
        .MAG_BITS (MAG_BITS)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (fr_valid),
        .s_sh     (fr_s),
        .t_sh     (fr_t),
        .x_in     (fr_x),
        .side_in  (fr_side),
        .valid    (sq_valid),
        .root     (sq_root),
        .x_out    (sq_x),
        .side_out (sq_side)
    );

    afi_cordic #(
        .MAG_BITS (MAG_BITS)
    ) u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (sq_valid),
        .y_in     (sq_root),
        .x_in     (sq_x),
        .side_in  (sq_side),
        .valid    (cd_valid),
        .angle    (cd_angle),
        .side_out (cd_side)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            out_valid     <= 1'b0;
        end
        else if (adv)
        begin
            mul_valid_reg <= cd_valid;
            out_valid     <= mul_valid_reg;
        end
    end

    // round half up, then saturate to 20 bits
    assign rnd = (MW+1)'(mul_reg) + ((MW+1)'(1) << 19);
    assign q   = 21'(rnd >> 20);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mul_reg      <= MW'(cd_angle) * MW'(inv_angle_reg);
            mul_side_reg <= cd_side;

            b0_first      <= mul_side_reg.b0_first;
            b0_second     <= mul_side_reg.b0_second;
            in_mask       <= mul_side_reg.in_mask;
            ratio_invalid <= mul_side_reg.ratio_invalid;
            if (mul_side_reg.ratio_invalid || !mul_side_reg.in_mask)
                flip_ratio <= '0;
            else if (q[20])
                flip_ratio <= 20'hFFFFF;
            else
                flip_ratio <= q[19:0];
        end
    end

endmodule

[tb/afi_flip_angle_b0_voxel_tb.sv]
// Self-checking testbench for the AFI flip-angle and B0 voxel engine: directed and random voxels
// under random valid/stall gaps, checked against an in-bench fixed-point model.
// Depends on afi_pkg and afi_flip_angle_b0_voxel.
`timescale 1ns / 1ps

module afi_flip_angle_b0_voxel_tb;
    import afi_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd6;
    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        logic [11:0]        ma, mb, mc, md;
        logic signed [12:0] pa, pb, pc, pd;
    } voxel_t;

    typedef struct {
        logic [15:0] b0a, b0b;
        logic [19:0] flip;
        logic        mask, bad;
    } voxel_out_t;

    localparam longint ATAN_TBL [20] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
        58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};

    logic clk, rst_n;
    logic cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid, in_stall, out_valid, out_stall;
    logic [11:0] mag_a, mag_b, mag_c, mag_d;
    logic signed [12:0] pha_a, pha_b, pha_c, pha_d;
    logic signed [15:0] b0_first, b0_second;
    logic [19:0] flip_ratio;
    logic in_mask, ratio_invalid;

    logic [15:0] tr_n, inv_ang, scale1, scale2;
    logic [11:0] cutoff;

    voxel_t     voxel_feed[$];
    voxel_out_t voxel_results[$];
    int errors, n_in, in_gap, stall_gap, hold_cnt, idle_cycles;
    bit did_hold, no_idle;

    afi_flip_angle_b0_voxel u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .mag_a(mag_a), .mag_b(mag_b), .mag_c(mag_c), .mag_d(mag_d),
        .pha_a(pha_a), .pha_b(pha_b), .pha_c(pha_c), .pha_d(pha_d),
        .out_valid(out_valid), .out_stall(out_stall),
        .b0_first(b0_first), .b0_second(b0_second), .flip_ratio(flip_ratio),
        .in_mask(in_mask), .ratio_invalid(ratio_invalid)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint wrap13(longint d);
        if (d > 4096)
            d -= 8192;
        if (d <= -4096)
            d += 8192;
        return d;
    endfunction

    function automatic logic [15:0] b0_offset(longint d, logic [15:0] sc, logic [11:0] m1,
                                              logic [11:0] m2);
        longint v;
        if (m1 == 0 || m2 == 0)
            return 16'd0;
        v = (d * longint'(sc) + 4096) >>> 13;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // acos(num/den) in degrees Q16, den > 0, |num| <= den
    function automatic longint acos_q16(longint num, longint den);
        longint unsigned s, t;
        longint x, y, z, ax, nx, ny;
        int k;
        s = den - num;
        t = den + num;
        k = 0;
        z = 0;
        while ((s >> k) >= 64'h1_0000_0000 || (t >> k) >= 64'h1_0000_0000)
            k++;
        y = int_sqrt((s >> k) * (t >> k));
        x = num >>> k;
        for (int n = 0; n < 62; n++)
        begin
            ax = x < 0 ? -x : x;
            if (ax >= (64'sd1 << 30) || y >= (64'sd1 << 30) || (ax == 0 && y == 0))
                break;
            x *= 2;
            y *= 2;
        end
        if (x < 0)
        begin
            nx = y;
            y = -x;
            x = nx;
            z = 90 * 65536;
        end
        for (int i = 0; i < 20; i++)
        begin
            if (y > 0)
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += ATAN_TBL[i];
            end
            else
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= ATAN_TBL[i];
            end
            x = nx;
            y = ny;
        end
        if (z < 0)
            z = 0;
        if (z > 180 * 65536)
            z = 180 * 65536;
        return z;
    endfunction

    function automatic voxel_out_t calc_voxel(voxel_t v);
        voxel_out_t r;
        longint d01, f, num, den, anum, aden, fl;
        d01 = wrap13(longint'(v.pb) - longint'(v.pa));
        f = ((d01 < 0 ? -d01 : d01) >= 2048) ? -1 : 1;
        num = f * longint'(v.mb) * longint'(tr_n) - 4096 * longint'(v.ma);
        den = longint'(tr_n) * longint'(v.ma) - f * longint'(v.mb) * 4096;
        anum = num < 0 ? -num : num;
        aden = den < 0 ? -den : den;
        r.bad = (v.ma == 0) || (den == 0) || (anum > aden);
        r.mask = v.ma >= cutoff;
        r.flip = '0;
        if (!r.bad && r.mask)
        begin
            if (den < 0)
            begin
                num = -num;
                den = -den;
            end
            fl = (acos_q16(num, den) * longint'(inv_ang) + (64'sd1 << 19)) >>> 20;
            r.flip = (fl > 20'hFFFFF) ? 20'hFFFFF : fl[19:0];
        end
        r.b0a = b0_offset(wrap13(longint'(v.pc) - longint'(v.pa)), scale1, v.ma, v.mc);
        r.b0b = b0_offset(wrap13(longint'(v.pd) - longint'(v.pc)), scale2, v.mc, v.md);
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                voxel_results.push_back(calc_voxel('{mag_a, mag_b, mag_c, mag_d,
                                                     pha_a, pha_b, pha_c, pha_d}));
                n_in++;
            end
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (voxel_feed.size() > 0)
                begin
                    voxel_t v;
                    v = voxel_feed.pop_front();
                    mag_a <= v.ma; mag_b <= v.mb; mag_c <= v.mc; mag_d <= v.md;
                    pha_a <= v.pa; pha_b <= v.pb; pha_c <= v.pc; pha_d <= v.pd;
                    in_valid <= 1'b1;
                    in_gap = no_idle ? 0 : pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    task automatic report(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // monitor and receiver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (voxel_results.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, actual b0 %h %h flip %h",
                             $time, b0_first, b0_second, flip_ratio);
                    errors++;
                end
                else
                begin
                    voxel_out_t e;
                    e = voxel_results.pop_front();
                    report("b0_first", e.b0a, $unsigned(b0_first));
                    report("b0_second", e.b0b, $unsigned(b0_second));
                    report("flip_ratio", e.flip, flip_ratio);
                    report("in_mask", e.mask, in_mask);
                    report("ratio_invalid", e.bad, ratio_invalid);
                end
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                out_stall <= 1'b1;
            end
            else if (!did_hold && n_in >= 300)
            begin
                did_hold = 1'b1;
                hold_cnt = 400;
                out_stall <= 1'b1;
            end
            else if (stall_gap > 0)
            begin
                stall_gap--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                stall_gap = no_idle ? 0 : pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("afi_flip_angle_b0_voxel test failed");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_REP_RATIO: tr_n    = val;
            REG_INV_ANGLE: inv_ang = val;
            REG_CUTOFF:    cutoff  = val[11:0];
            REG_B0_FIRST:  scale1  = val;
            REG_B0_SECOND: scale2  = val;
            default: ;
        endcase
    endtask

    task automatic set_regs(logic [15:0] n, logic [15:0] ia, logic [15:0] co,
                            logic [15:0] s1, logic [15:0] s2);
        write_reg(REG_REP_RATIO, n);
        write_reg(REG_INV_ANGLE, ia);
        write_reg(REG_CUTOFF, co);
        write_reg(REG_B0_FIRST, s1);
        write_reg(REG_B0_SECOND, s2);
        write_reg(REG_SPARE, 16'($urandom));
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic add_voxel(int ma, int mb, int mc, int md, int pa, int pb, int pc, int pd);
        voxel_feed.push_back('{ma[11:0], mb[11:0], mc[11:0], md[11:0],
                               pa[12:0], pb[12:0], pc[12:0], pd[12:0]});
    endtask

    task automatic add_random(int count);
        int ma, mb;
        repeat (count)
        begin
            ma = $urandom_range(0, 4095);
            if ($urandom_range(0, 2) == 0)
                mb = $urandom_range(0, 4095);
            else
                mb = ma * $urandom_range(0, 100) / 100;
            if ($urandom_range(0, 15) == 0)
                ma = $urandom_range(0, 200);
            add_voxel(ma, mb, $urandom_range(0, 4095), $urandom_range(0, 4095),
                      $urandom_range(0, 8191) - 4096, $urandom_range(0, 8191) - 4096,
                      $urandom_range(0, 8191) - 4096, $urandom_range(0, 8191) - 4096);
        end
    endtask

    task automatic drain();
        while (voxel_feed.size() > 0 || voxel_results.size() > 0 || in_valid)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0; cfg_index = '0; cfg_data = '0;
        in_valid = 1'b0; out_stall = 1'b0;
        mag_a = '0; mag_b = '0; mag_c = '0; mag_d = '0;
        pha_a = '0; pha_b = '0; pha_c = '0; pha_d = '0;
        tr_n = REP_RATIO_RST; inv_ang = INV_ANGLE_RST; cutoff = CUTOFF_RST;
        scale1 = B0_SCALE_RST; scale2 = B0_SCALE_RST;
        errors = 0; n_in = 0; in_gap = 0; stall_gap = 0; hold_cnt = 0; idle_cycles = 0;
        did_hold = 1'b0; no_idle = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed voxels at reset settings
        add_voxel(0, 0, 0, 0, 0, 0, 0, 0);
        add_voxel(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095);
        add_voxel(4095, 4095, 4095, 4095, -4096, -4096, -4096, -4096);
        add_voxel(1000, 500, 800, 800, 0, -4096, -4096, 0);        // difference of pi
        add_voxel(1000, 500, 800, 800, 0, 2048, 2047, 4095);       // phase on 90 degrees
        add_voxel(1000, 500, 800, 800, 0, 2047, -2048, 2048);
        add_voxel(0, 500, 800, 800, 100, 200, 300, 400);           // mag_a zero
        add_voxel(1, 5, 800, 800, 0, 0, 0, 0);                     // zero denominator
        add_voxel(200, 1000, 800, 800, 0, 0, 0, 0);
        add_voxel(100, 4095, 800, 800, 0, 0, 0, 0);                // acos out of range
        add_voxel(99, 50, 800, 800, 0, 0, 0, 0);                   // masked
        add_voxel(100, 50, 800, 800, 0, 0, 0, 0);
        add_voxel(2000, 2000, 0, 700, -4000, 10, 3000, -3000);     // zero magnitude pair
        add_voxel(2000, 2000, 700, 0, 4095, -4096, 0, 4095);
        add_voxel(4095, 0, 1, 1, -1, 1, -4096, 4095);
        add_voxel(4095, 1, 2730, 1365, 1365, -2730, 1, -1);
        add_voxel(3000, 2900, 2048, 2047, 0, 100, 4095, -4096);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_regs(REP_RATIO_RST, INV_ANGLE_RST, 16'(CUTOFF_RST), B0_SCALE_RST,
                            B0_SCALE_RST);
                1: set_regs(16'd4096, 16'd65535, 16'd0, 16'd65535, 16'd65535);
                2: set_regs(16'd65535, 16'd1, 16'd4095, 16'd1, 16'd1);
                3: set_regs(16'd0, 16'hFFFF, 16'hFFFF, 16'd32768, 16'd8000);
                default: set_regs(16'($urandom_range(4096, 65535)),
                                  16'($urandom_range(1, 65535)),
                                  16'($urandom_range(0, 4095)),
                                  16'($urandom_range(1, 65535)),
                                  16'($urandom_range(1, 65535)));
            endcase
            no_idle = (ph == 4);
            add_random(190);
            drain();
        end

        if (errors == 0)
            $display("afi_flip_angle_b0_voxel test passed");
        else
            $display("afi_flip_angle_b0_voxel test failed");
        $finish;
    end

endmodule

[afi_flip_angle_b0_voxel.f]
sv/afi_pkg.sv
sv/afi_front.sv
sv/afi_isqrt.sv
sv/afi_cordic.sv
sv/afi_flip_angle_b0_voxel.sv
tb/afi_flip_angle_b0_voxel_tb.sv
